FILE: rtl/csv_pkg.sv
// Package for the slider-crank cylinder volume unit.
// Widths, register indexes, stage payload types and the CORDIC arctangent table.
// No dependencies.
package csv_pkg;

  localparam int ANGLE_BITS      = 16;
  localparam int TRIG_ITERATIONS = 18;

  localparam int XY_W   = 33;
  localparam int Z_W    = 34;
  localparam int DEFP_W = 58;
  localparam int DEF_W  = 34;
  localparam int RC_W   = 30;
  localparam int ARG_W  = 56;
  localparam int ROOT_W = ARG_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  localparam logic signed [XY_W-1:0] CORDIC_ONE_K = XY_W'(652032874);

  typedef enum logic [2:0] {
    REG_CRANK_RADIUS     = 3'd0,
    REG_ROD_LENGTH       = 3'd1,
    REG_PIN_OFFSET       = 3'd2,
    REG_ANGLE_OFFSET     = 3'd3,
    REG_MAX_DISTANCE     = 3'd4,
    REG_PISTON_AREA      = 3'd5,
    REG_CLEARANCE_VOLUME = 3'd6,
    REG_PRESSURE_GAIN    = 3'd7
  } csv_reg_t;

  typedef struct packed {
    logic signed [RC_W-1:0] rc8;
    logic [DEF_W-1:0]       def8;
    logic                   err;
  } csv_sside_t;

  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/csv_cordic.sv
// Pipelined CORDIC rotation, one iteration per register stage.
// Produces Q30 cosine and sine of a folded angle. Depends on csv_pkg.
module csv_cordic (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [csv_pkg::Z_W-1:0]  in_z,
  input  logic                        in_neg,
  input  logic [csv_pkg::DEFP_W-1:0]  in_side,
  output logic                        out_valid,
  output logic signed [csv_pkg::XY_W-1:0] out_cos,
  output logic signed [csv_pkg::XY_W-1:0] out_sin,
  output logic [csv_pkg::DEFP_W-1:0]  out_side
);
  import csv_pkg::*;

  localparam int N = TRIG_ITERATIONS;

  logic                   v_w    [N+1];
  logic signed [XY_W-1:0] x_w    [N+1];
  logic signed [XY_W-1:0] y_w    [N+1];
  logic signed [Z_W-1:0]  z_w    [N+1];
  logic                   neg_w  [N+1];
  logic [DEFP_W-1:0]      side_w [N+1];

  assign v_w[0]    = in_valid;
  assign x_w[0]    = CORDIC_ONE_K;
  assign y_w[0]    = '0;
  assign z_w[0]    = in_z;
  assign neg_w[0]  = in_neg;
  assign side_w[0] = in_side;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                   v_r;
    logic signed [XY_W-1:0] x_r, y_r;
    logic signed [Z_W-1:0]  z_r;
    logic                   neg_r;
    logic [DEFP_W-1:0]      side_r;
    logic signed [XY_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  at;

    assign dx = y_w[i] >>> i;
    assign dy = x_w[i] >>> i;
    assign at = $signed({2'b00, atan_turn(i)});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_w[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_w[i][Z_W-1]) begin
          x_r <= x_w[i] - dx;
          y_r <= y_w[i] + dy;
          z_r <= z_w[i] - at;
        end else begin
          x_r <= x_w[i] + dx;
          y_r <= y_w[i] - dy;
          z_r <= z_w[i] + at;
        end
        neg_r  <= neg_w[i];
        side_r <= side_w[i];
      end
    end

    assign v_w[i+1]    = v_r;
    assign x_w[i+1]    = x_r;
    assign y_w[i+1]    = y_r;
    assign z_w[i+1]    = z_r;
    assign neg_w[i+1]  = neg_r;
    assign side_w[i+1] = side_r;
  end

  assign out_valid = v_w[N];
  assign out_cos   = neg_w[N] ? -x_w[N] : x_w[N];
  assign out_sin   = neg_w[N] ? -y_w[N] : y_w[N];
  assign out_side  = side_w[N];

endmodule

FILE: rtl/csv_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Floor root of an unsigned argument; carries a side payload. Depends on csv_pkg.
module csv_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [csv_pkg::ARG_W-1:0]  in_arg,
  input  csv_pkg::csv_sside_t        in_side,
  output logic                       out_valid,
  output logic [csv_pkg::ROOT_W-1:0] out_root,
  output csv_pkg::csv_sside_t        out_side
);
  import csv_pkg::*;

  logic               v_w    [ROOT_W+1];
  logic [ARG_W-1:0]   a_w    [ROOT_W+1];
  logic [REM_W-1:0]   rem_w  [ROOT_W+1];
  logic [ROOT_W-1:0]  root_w [ROOT_W+1];
  csv_sside_t         side_w [ROOT_W+1];

  assign v_w[0]    = in_valid;
  assign a_w[0]    = in_arg;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign side_w[0] = in_side;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              v_r;
    logic [ARG_W-1:0]  a_r;
    logic [REM_W-1:0]  rem_r;
    logic [ROOT_W-1:0] root_r;
    csv_sside_t        side_r;
    logic [REM_W-1:0]  rem_sh, trial;

    assign rem_sh = {rem_w[k][REM_W-3:0], a_w[k][ARG_W-1 -: 2]};
    assign trial  = {root_w[k], 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r    <= a_w[k] << 2;
        side_r <= side_w[k];
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_w[k][ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_w[k][ROOT_W-2:0], 1'b0};
        end
      end
    end

    assign v_w[k+1]    = v_r;
    assign a_w[k+1]    = a_r;
    assign rem_w[k+1]  = rem_r;
    assign root_w[k+1] = root_r;
    assign side_w[k+1] = side_r;
  end

  assign out_valid = v_w[ROOT_W];
  assign out_root  = root_w[ROOT_W];
  assign out_side  = side_w[ROOT_W];

endmodule

FILE: rtl/crank_slider_cylinder_volume_unit.sv
// Top level of the offset slider-crank displacement and cylinder volume unit.
// Instantiates csv_cordic and csv_isqrt; depends on csv_pkg.
//
// Usage:
//  - Input channel in_valid/in_ready carries crank_angle, pressure and mode.
//  - Output channel out_valid/out_ready carries displacement, volume and
//    root_error, one result per input, in order.
//  - Configuration: cfg_we writes cfg_data to register cfg_index at the clock
//    edge; write only while the pipeline is empty.
//  - The pipeline has one fold stage, 18 CORDIC stages, four multiply/square
//    stages, 28 square-root stages and three volume stages.
//  - Throughput is one item per cycle when not stalled; every stage is registered.
//  - When the receiver stalls with a result held, the whole pipeline freezes
//    and in_ready drops; nothing is lost or repeated.
//  - Synchronous reset clears all valid bits and loads the register defaults.
module crank_slider_cylinder_volume_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [43:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_crank_angle,
  input  logic [25:0]        in_pressure,
  input  logic               in_mode,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [21:0] out_displacement,
  output logic [44:0]        out_volume,
  output logic               out_root_error
);
  import csv_pkg::*;

  logic [19:0]        crank_radius_r, rod_length_r, piston_area_r;
  logic signed [19:0] pin_offset_r;
  logic [15:0]        angle_offset_r;
  logic [20:0]        max_distance_r;
  logic [43:0]        clearance_volume_r;
  logic [31:0]        pressure_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crank_radius_r     <= 20'd45000;
      rod_length_r       <= 20'd145000;
      pin_offset_r       <= '0;
      angle_offset_r     <= '0;
      max_distance_r     <= 21'd190000;
      piston_area_r      <= 20'd6362;
      clearance_volume_r <= '0;
      pressure_gain_r    <= '0;
    end else if (cfg_we) begin
      case (csv_reg_t'(cfg_index))
        REG_CRANK_RADIUS:     crank_radius_r     <= cfg_data[19:0];
        REG_ROD_LENGTH:       rod_length_r       <= cfg_data[19:0];
        REG_PIN_OFFSET:       pin_offset_r       <= $signed(cfg_data[19:0]);
        REG_ANGLE_OFFSET:     angle_offset_r     <= cfg_data[15:0];
        REG_MAX_DISTANCE:     max_distance_r     <= cfg_data[20:0];
        REG_PISTON_AREA:      piston_area_r      <= cfg_data[19:0];
        REG_CLEARANCE_VOLUME: clearance_volume_r <= cfg_data[43:0];
        REG_PRESSURE_GAIN:    pressure_gain_r    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // fold stage
  logic [ANGLE_BITS-1:0] ang;
  logic [31:0]           t0, t1;
  logic                  fold;
  logic                  s0_valid_r, s0_neg_r;
  logic signed [Z_W-1:0] s0_z_r;
  logic [DEFP_W-1:0]     s0_defp_r;

  assign ang  = ANGLE_BITS'(32'(in_crank_angle) + 32'(angle_offset_r));
  assign t0   = 32'(ang) << (32 - ANGLE_BITS);
  assign fold = t0[31] ^ t0[30];
  assign t1   = fold ? t0 - 32'h8000_0000 : t0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_neg_r  <= fold;
      s0_z_r    <= Z_W'($signed(t1));
      s0_defp_r <= in_mode ? '0 : DEFP_W'(in_pressure) * DEFP_W'(pressure_gain_r);
    end
  end

  logic                   c_valid;
  logic signed [XY_W-1:0] c_cos, c_sin;
  logic [DEFP_W-1:0]      c_defp;

  csv_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_valid_r),
    .in_z      (s0_z_r),
    .in_neg    (s0_neg_r),
    .in_side   (s0_defp_r),
    .out_valid (c_valid),
    .out_cos   (c_cos),
    .out_sin   (c_sin),
    .out_side  (c_defp)
  );

  // r cos, r sin, deformation
  logic signed [XY_W+21-1:0] pc, ps;
  logic                      m_valid_r;
  logic signed [RC_W-1:0]    m_rc8_r, m_rs8_r;
  logic [DEF_W-1:0]          m_def8_r;

  assign pc = $signed({1'b0, crank_radius_r}) * c_cos + (54'sd1 <<< 21);
  assign ps = $signed({1'b0, crank_radius_r}) * c_sin + (54'sd1 <<< 21);

  // d = r sin - 256 e
  logic                   d_valid_r;
  logic signed [30:0]     d_r;
  logic signed [RC_W-1:0] d_rc8_r;
  logic [DEF_W-1:0]       d_def8_r;

  // squares
  logic                   q_valid_r;
  logic signed [61:0]     q_dsq_r;
  logic [39:0]            q_lsq_r;
  logic signed [RC_W-1:0] q_rc8_r;
  logic [DEF_W-1:0]       q_def8_r;

  // root argument
  logic signed [59:0] arg;
  logic               a_valid_r;
  logic [ARG_W-1:0]   a_arg_r;
  csv_sside_t         a_side_r;

  assign arg = $signed({4'b0, q_lsq_r, 16'b0}) - 60'(q_dsq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      q_valid_r <= 1'b0;
      a_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= c_valid;
      d_valid_r <= m_valid_r;
      q_valid_r <= d_valid_r;
      a_valid_r <= q_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_rc8_r  <= RC_W'(pc >>> 22);
      m_rs8_r  <= RC_W'(ps >>> 22);
      m_def8_r <= DEF_W'((c_defp + DEFP_W'(1 << 23)) >> 24);

      d_r      <= 31'(m_rs8_r) - (31'(pin_offset_r) <<< 8);
      d_rc8_r  <= m_rc8_r;
      d_def8_r <= m_def8_r;

      q_dsq_r  <= d_r * d_r;
      q_lsq_r  <= 40'(rod_length_r) * 40'(rod_length_r);
      q_rc8_r  <= d_rc8_r;
      q_def8_r <= d_def8_r;

      a_arg_r       <= arg[59] ? '0 : arg[ARG_W-1:0];
      a_side_r.err  <= arg[59];
      a_side_r.rc8  <= q_rc8_r;
      a_side_r.def8 <= q_def8_r;
    end
  end

  logic              r_valid;
  logic [ROOT_W-1:0] r_root;
  csv_sside_t        r_side;

  csv_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (a_valid_r),
    .in_arg    (a_arg_r),
    .in_side   (a_side_r),
    .out_valid (r_valid),
    .out_root  (r_root),
    .out_side  (r_side)
  );

  // displacement and volume
  logic               p_valid_r, p_err_r;
  logic signed [36:0] p_disp8_r;
  logic               v_valid_r, v_err_r;
  logic signed [57:0] v_prod_r;
  logic signed [21:0] v_disp_r;
  logic signed [28:0] disp_rnd;
  logic signed [49:0] prod_rnd;
  logic signed [50:0] vol;

  assign disp_rnd = 29'((p_disp8_r + 37'sd128) >>> 8);
  assign prod_rnd = 50'((v_prod_r + 58'sd128) >>> 8);
  assign vol      = 51'(prod_rnd) + $signed({7'b0, clearance_volume_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      v_valid_r <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid_r <= r_valid;
      v_valid_r <= p_valid_r;
      out_valid <= v_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_disp8_r <= $signed({8'b0, max_distance_r, 8'b0}) - 37'(r_side.rc8)
                   - $signed({9'b0, r_root}) + $signed({3'b0, r_side.def8});
      p_err_r   <= r_side.err;

      v_prod_r  <= $signed({1'b0, piston_area_r}) * p_disp8_r;
      v_err_r   <= p_err_r;
      if (disp_rnd > 29'sd2097151) begin
        v_disp_r <= 22'sd2097151;
      end else if (disp_rnd < -29'sd2097152) begin
        v_disp_r <= -22'sd2097152;
      end else begin
        v_disp_r <= 22'(disp_rnd);
      end

      out_displacement <= v_disp_r;
      out_root_error   <= v_err_r;
      if (vol[50]) begin
        out_volume <= '0;
      end else if (vol[49:45] != '0) begin
        out_volume <= '1;
      end else begin
        out_volume <= vol[44:0];
      end
    end
  end

endmodule

FILE: test/crank_slider_cylinder_volume_unit_tb.sv
// Testbench for crank_slider_cylinder_volume_unit: directed and random transfers checked
// against a built-in predictor of the slider-crank geometry and the volume arithmetic.
// Depends on csv_pkg and the RTL of the unit; needs no files or arguments.
module crank_slider_cylinder_volume_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csv_pkg::*;

  typedef struct {
    logic signed [21:0] disp;
    logic [44:0]        vol;
    logic               err;
  } cyl_result_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 70;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [43:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_crank_angle = '0;
  logic [25:0] in_pressure = '0;
  logic in_mode = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [21:0] out_displacement;
  logic [44:0] out_volume;
  logic out_root_error;

  cyl_result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int root_errors_seen = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;
  int stall_left = 0;

  // predictor copy of the register file
  longint g_radius, g_rod, g_pin, g_aoff, g_maxd, g_area, g_clear, g_gain;

  longint turn_atan[18] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215};

  always #1 clk = ~clk;

  crank_slider_cylinder_volume_unit dut (.*);

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic cyl_result_t calc_cylinder(logic [15:0] angle, logic [25:0] press,
                                                logic mode);
    cyl_result_t r;
    logic [15:0] ang;
    logic [31:0] t;
    bit flip;
    longint x, y, z, dx, dy, c, s, rc8, rs8, d, l8, arg, disp8, disp, vol;
    longint unsigned root, def8;
    ang = angle + g_aoff[15:0];
    t = {ang, 16'h0};
    flip = 1'b0;
    if (((t + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      t = t - 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'($signed(t));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 18; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= turn_atan[i];
      end else begin
        x += dx; y -= dy; z += turn_atan[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    rc8 = (g_radius * c + 2097152) >>> 22;
    rs8 = (g_radius * s + 2097152) >>> 22;
    d = rs8 - g_pin * 256;
    l8 = g_rod * 256;
    arg = l8 * l8 - d * d;
    r.err = 1'b0;
    if (arg < 0) begin
      arg = 0;
      r.err = 1'b1;
    end
    root = int_sqrt(longint'(arg));
    def8 = 0;
    if (mode == 1'b0)
      def8 = (longint'(press) * g_gain + 64'd8388608) >> 24;
    disp8 = g_maxd * 256 - rc8 - longint'(root) + longint'(def8);
    disp = (disp8 + 128) >>> 8;
    if (disp > 2097151) disp = 2097151;
    if (disp < -2097152) disp = -2097152;
    vol = g_clear + ((g_area * disp8 + 128) >>> 8);
    if (vol < 0) vol = 0;
    if (vol > 64'h1FFF_FFFF_FFFF) vol = 64'h1FFF_FFFF_FFFF;
    r.disp = disp[21:0];
    r.vol = vol[44:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    if (no_gaps) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (no_gaps) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(99) < 25)
        stall_left <= ($urandom_range(99) < 90) ? $urandom_range(3, 1) : $urandom_range(40, 10);
    end
  end

  // result checking
  always @(posedge clk) begin
    cyl_result_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_root_error) root_errors_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: displacement %0d volume %0d", out_displacement, out_volume);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_displacement !== e.disp) begin
          $error("displacement: expected %0d, got %0d", e.disp, out_displacement);
          errors++;
        end
        if (out_volume !== e.vol) begin
          $error("volume: expected %0d, got %0d", e.vol, out_volume);
          errors++;
        end
        if (out_root_error !== e.err) begin
          $error("root_error: expected %0b, got %0b", e.err, out_root_error);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("crank_slider_cylinder_volume_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic send_item(logic [15:0] angle, logic [25:0] press, logic mode);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_crank_angle <= angle;
    in_pressure <= press;
    in_mode <= mode;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(calc_cylinder(angle, press, mode));
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(csv_reg_t idx, logic [43:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_CRANK_RADIUS:     g_radius = longint'(v[19:0]);
      REG_ROD_LENGTH:       g_rod = longint'(v[19:0]);
      REG_PIN_OFFSET:       g_pin = longint'($signed(v[19:0]));
      REG_ANGLE_OFFSET:     g_aoff = longint'(v[15:0]);
      REG_MAX_DISTANCE:     g_maxd = longint'(v[20:0]);
      REG_PISTON_AREA:      g_area = longint'(v[19:0]);
      REG_CLEARANCE_VOLUME: g_clear = longint'(v[43:0]);
      REG_PRESSURE_GAIN:    g_gain = longint'(v[31:0]);
      default: ;
    endcase
  endtask

  task automatic write_all(longint r, longint l, longint e, longint ao, longint md,
                           longint a, longint cv, longint g);
    wait_idle();
    write_reg(REG_CRANK_RADIUS, 44'(r));
    write_reg(REG_ROD_LENGTH, 44'(l));
    write_reg(REG_PIN_OFFSET, 44'(e));
    write_reg(REG_ANGLE_OFFSET, 44'(ao));
    write_reg(REG_MAX_DISTANCE, 44'(md));
    write_reg(REG_PISTON_AREA, 44'(a));
    write_reg(REG_CLEARANCE_VOLUME, 44'(cv));
    write_reg(REG_PRESSURE_GAIN, 44'(g));
    cfg_we <= 1'b0;
  endtask

  // default registers: quadrant points, pressure extremes, both modes
  task automatic test_reset_defaults();
    send_item(16'd0, 26'd0, 1'b0);
    send_item(16'd16384, 26'h3FFFFFF, 1'b0);
    send_item(16'd32768, 26'h3FFFFFF, 1'b1);
    send_item(16'd49152, 26'd1000, 1'b0);
    send_item(16'hFFFF, 26'd0, 1'b1);
    send_item(16'd8192, 26'h2AAAAAA, 1'b0);
  endtask

  task automatic test_corner_settings();
    // rod shorter than the crank: negative root argument, max gain, angle wrap
    write_all(64'hFFFFF, 0, 0, 64'hFFFF, 64'h1FFFFF, 64'hFFFFF, 0, 64'hFFFFFFFF);
    send_item(16'd16385, 26'h3FFFFFF, 1'b0);
    send_item(16'd1, 26'h3FFFFFF, 1'b1);
    send_item(16'd32769, 26'd0, 1'b0);
    // extreme pin offsets, full clearance
    write_all(45000, 145000, 64'h80000, 100, 64'h1FFFFF, 64'hFFFFF, 64'hFFF_FFFF_FFFF, 0);
    send_item(16'd0, 26'd0, 1'b1);
    send_item(16'd16384, 26'd5, 1'b0);
    write_all(45000, 64'hFFFFF, 64'h7FFFF, 0, 0, 64'hFFFFF, 0, 64'hFFFFFFFF);
    send_item(16'd49152, 26'h3FFFFFF, 1'b1);
    send_item(16'd0, 26'h3FFFFFF, 1'b0);
    // big rod, no max distance, most negative pin offset
    write_all(64'hFFFFF, 64'hFFFFF, 64'h80000, 0, 0, 64'hFFFFF, 0, 0);
    send_item(16'd32768, 26'd0, 1'b1);
    send_item(16'd16384, 26'h155555, 1'b0);
    // everything zero
    write_all(0, 0, 0, 0, 0, 0, 0, 0);
    send_item(16'h5555, 26'h3FFFFFF, 1'b0);
    send_item(16'hAAAA, 26'h0, 1'b1);
  endtask

  task automatic test_random_sweep(int phases, int per_phase);
    longint r, l;
    for (int ph = 0; ph < phases; ph++) begin
      no_gaps = (ph % 5 == 3);
      if ($urandom_range(3) != 0) begin
        r = $urandom_range(90000, 5000);
        l = r * $urandom_range(5, 2) + $urandom_range(2000);
        write_all(r, l, $signed($urandom_range(20000)) - 10000, $urandom_range(65535),
                  r + l + $urandom_range(20000), $urandom_range(20000, 100),
                  $urandom_range(500000000), $urandom);
      end else begin
        write_all($urandom_range(20'hFFFFF), $urandom_range(20'hFFFFF), $urandom_range(20'hFFFFF),
                  $urandom_range(65535), $urandom_range(21'h1FFFFF), $urandom_range(20'hFFFFF),
                  {$urandom_range(12'hFFF), $urandom}, $urandom);
      end
      for (int k = 0; k < per_phase; k++)
        send_item(16'($urandom_range(65535)), 26'($urandom_range(26'h3FFFFFF)),
                  1'($urandom_range(1)));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    g_radius = 45000; g_rod = 145000; g_pin = 0; g_aoff = 0;
    g_maxd = 190000; g_area = 6362; g_clear = 0; g_gain = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_corner_settings();
    test_random_sweep(20, 80);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d transfers, %0d results (%0d with root error)",
             items_sent, results_seen, root_errors_seen);
    $display("register sweeps: defaults, corner settings and 20 random settings");
    if (errors == 0)
      $display("crank_slider_cylinder_volume_unit_tb: PASS");
    else
      $display("crank_slider_cylinder_volume_unit_tb: FAIL");
    $finish;
  end

endmodule
